>>> design/madt_pkg.sv
// ----------------------------------------------------------------------------
// madt_pkg
// Shared types and constants for the MADT stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package madt_pkg;

  // "APIC", byte 0 in the low lane
  localparam logic [31:0] MADT_SIGNATURE = 32'h4349_5041;

  localparam int unsigned MAX_OUT          = 16;
  localparam int unsigned BASE_AT          = 36;
  localparam int unsigned ENTRIES_AT       = 44;
  localparam logic [7:0]  TYPE_LAPIC       = 8'd0;
  localparam logic [7:0]  TYPE_LAPIC_OVR   = 8'd5;
  localparam logic [7:0]  LAPIC_MIN_LEN    = 8'd8;
  localparam logic [7:0]  OVERRIDE_MIN_LEN = 8'd12;
  localparam logic [7:0]  ENTRY_MIN_LEN    = 8'd2;
  localparam logic [7:0]  NO_ID            = 8'hFF;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SIG = 2'd1;
  localparam logic [1:0] ST_BAD_SUM = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  // summary of one finished table, handed from parser to emitter
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] lapic_base;
    logic [4:0]  usable_cpus;
    logic        has_ids;
    logic [3:0]  last_idx;
  } madt_job_t;

endpackage

`default_nettype wire

>>> design/madt_if.sv
// ----------------------------------------------------------------------------
// madt_in_if / madt_out_if
// Valid/ready channels for table bytes and parse results.
// ----------------------------------------------------------------------------
`default_nettype none

interface madt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       stream_end;

  modport source (output valid, output table_byte, output stream_end, input ready);
  modport sink   (input valid, input table_byte, input stream_end, output ready);
endinterface

interface madt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] lapic_base;
  logic [4:0]  usable_cpus;
  logic [3:0]  cpu_slot;
  logic [7:0]  apic_id;
  logic        last_result;

  modport source (output valid, output status, output lapic_base, output usable_cpus,
                  output cpu_slot, output apic_id, output last_result, input ready);
  modport sink   (input valid, input status, input lapic_base, input usable_cpus,
                  input cpu_slot, input apic_id, input last_result, output ready);
endinterface

`default_nettype wire

>>> design/madt_parse.sv
// ----------------------------------------------------------------------------
// madt_parse
// Input register and per-byte table parser; hands a job summary out at table or stream end.
// ----------------------------------------------------------------------------
`default_nettype none

module madt_parse
  import madt_pkg::*;
#(
  parameter int unsigned MAX_CPUS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_table_byte,
  input  wire logic       in_stream_end,
  output logic            job_valid,
  input  wire logic       job_ready,
  output madt_job_t       job,
  output logic [7:0]      job_list [(MAX_CPUS < MAX_OUT) ? MAX_CPUS : MAX_OUT]
);

  localparam int unsigned LIST_DEPTH = (MAX_CPUS < MAX_OUT) ? MAX_CPUS : MAX_OUT;
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_CPUS + 1);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // parse state
  logic [31:0]      off_r,  off_nxt;
  logic [31:0]      tl_r,   tl_nxt;
  logic [7:0]       sum_r,  sum_nxt;
  logic             sig_r,  sig_nxt;
  logic [7:0]       eo_r,   eo_nxt;
  logic [7:0]       et_r,   et_nxt;
  logic [7:0]       el_r,   el_nxt;
  logic             stop_r, stop_nxt;
  logic [7:0]       pid_r,  pid_nxt;
  logic [63:0]      os_r,   os_nxt;
  logic [63:0]      base_r, base_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [7:0]       list_r   [LIST_DEPTH];
  logic [7:0]       list_nxt [LIST_DEPTH];

  logic [7:0]  b;
  logic [7:0]  len_cur;
  logic [1:0]  flags;
  logic [63:0] os_new;
  logic [7:0]  cnt8;
  logic        done, fin, adv;
  logic [1:0]  status;
  logic        has_ids;

  assign b = s1_byte_r;

  always_comb begin
    off_nxt  = off_r + 32'd1;
    tl_nxt   = tl_r;
    sum_nxt  = sum_r + b;
    sig_nxt  = sig_r;
    eo_nxt   = eo_r;
    et_nxt   = et_r;
    el_nxt   = el_r;
    stop_nxt = stop_r;
    pid_nxt  = pid_r;
    os_nxt   = os_r;
    base_nxt = base_r;
    cnt_nxt  = cnt_r;
    list_nxt = list_r;
    len_cur  = (eo_r == 8'd1) ? b : el_r;
    flags    = b[1:0];
    os_new   = os_r | (64'(b) << {3'(eo_r - 8'd4), 3'b000});

    if (off_r < 32'd4) begin
      if (b != MADT_SIGNATURE[{off_r[1:0], 3'b000} +: 8]) sig_nxt = 1'b0;
    end else if (off_r < 32'd8) begin
      tl_nxt = tl_r | (32'(b) << {off_r[1:0], 3'b000});
    end else if (off_r >= 32'(BASE_AT) && off_r < 32'(BASE_AT + 4)) begin
      base_nxt = base_r | (64'(b) << {off_r[1:0], 3'b000});
    end else if (off_r >= 32'(ENTRIES_AT) && !stop_r) begin
      if (eo_r == 8'd1 &&
          (b < ENTRY_MIN_LEN ||
           ({1'b0, off_r - 32'd1} + 33'(b)) > {1'b0, tl_r})) begin
        // bad or overrunning entry: walk stops, offset left as is
        el_nxt   = b;
        stop_nxt = 1'b1;
      end else begin
        if (eo_r == 8'd0) begin
          et_nxt = b;
        end else if (eo_r == 8'd1) begin
          el_nxt = b;
        end else if (et_r == TYPE_LAPIC && el_r >= LAPIC_MIN_LEN) begin
          if (eo_r == 8'd3) pid_nxt = b;
          if (eo_r == 8'd4 && flags != 2'b00 && 8'(cnt_r) < 8'(MAX_CPUS)) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            if (8'(cnt_r) < 8'(LIST_DEPTH)) list_nxt[cnt_r[IDX_W-1:0]] = pid_r;
          end
        end else if (et_r == TYPE_LAPIC_OVR && el_r >= OVERRIDE_MIN_LEN) begin
          if (eo_r >= 8'd4 && eo_r <= 8'd11) begin
            os_nxt = os_new;
            if (eo_r == 8'd11) base_nxt = os_new;
          end
        end
        if (eo_r != 8'd0 && ({1'b0, eo_r} + 9'd1) >= {1'b0, len_cur}) begin
          eo_nxt = 8'd0;
          os_nxt = 64'd0;
        end else begin
          eo_nxt = eo_r + 8'd1;
        end
      end
    end
  end

  assign done = (off_r >= 32'd7) && (({1'b0, off_r} + 33'd1) >= {1'b0, tl_nxt});
  assign fin  = done || s1_end_r;
  assign adv  = s1_valid_r && (!fin || job_ready);
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    if (!done)          status = ST_TRUNC;
    else if (!sig_nxt)  status = ST_BAD_SIG;
    else if (sum_nxt != 8'd0) status = ST_BAD_SUM;
    else                status = ST_OK;
  end

  assign cnt8    = 8'(cnt_nxt);
  assign has_ids = (status == ST_OK) && (cnt8 != 8'd0);

  always_comb begin
    job.status      = status;
    job.lapic_base  = (status == ST_OK) ? base_nxt : 64'd0;
    job.has_ids     = has_ids;
    job.usable_cpus = !has_ids ? 5'd0 : ((cnt8 > 8'd31) ? 5'd31 : cnt8[4:0]);
    job.last_idx    = !has_ids ? 4'd0 : ((cnt8 >= 8'd16) ? 4'd15 : 4'(cnt8 - 8'd1));
  end

  assign job_valid = s1_valid_r && fin;
  assign job_list  = list_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_table_byte;
      s1_end_r  <= in_stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && fin)) begin
      off_r  <= 32'd0;
      tl_r   <= 32'd0;
      sum_r  <= 8'd0;
      sig_r  <= 1'b1;
      eo_r   <= 8'd0;
      et_r   <= 8'd0;
      el_r   <= 8'd0;
      stop_r <= 1'b0;
      pid_r  <= 8'd0;
      os_r   <= 64'd0;
      base_r <= 64'd0;
      cnt_r  <= '0;
    end else if (adv) begin
      off_r  <= off_nxt;
      tl_r   <= tl_nxt;
      sum_r  <= sum_nxt;
      sig_r  <= sig_nxt;
      eo_r   <= eo_nxt;
      et_r   <= et_nxt;
      el_r   <= el_nxt;
      stop_r <= stop_nxt;
      pid_r  <= pid_nxt;
      os_r   <= os_nxt;
      base_r <= base_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) list_r <= list_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    8'(cnt_r) <= 8'(MAX_CPUS))
    else $error("id count beyond MAX_CPUS");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(off_r)))
    else $error("stalled byte lost or state moved");

  a_fin_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && fin) |=> (off_r == 32'd0 && cnt_r == '0 && sig_r))
    else $error("table end did not restart the parser");

endmodule

`default_nettype wire

>>> design/madt_emit.sv
// ----------------------------------------------------------------------------
// madt_emit
// Holds one finished table and steps out its results, one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module madt_emit
  import madt_pkg::*;
#(
  parameter int unsigned MAX_CPUS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       job_valid,
  output logic            job_ready,
  input  wire madt_job_t  job,
  input  wire logic [7:0] job_list [(MAX_CPUS < MAX_OUT) ? MAX_CPUS : MAX_OUT],
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [63:0]     out_lapic_base,
  output logic [4:0]      out_usable_cpus,
  output logic [3:0]      out_cpu_slot,
  output logic [7:0]      out_apic_id,
  output logic            out_last_result
);

  localparam int unsigned LIST_DEPTH = (MAX_CPUS < MAX_OUT) ? MAX_CPUS : MAX_OUT;
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic       busy_r;
  logic [3:0] idx_r;
  madt_job_t  job_r;
  logic [7:0] list_r [LIST_DEPTH];

  logic out_fire, is_last, load;

  assign is_last   = (idx_r == job_r.last_idx);
  assign out_fire  = busy_r && out_ready;
  assign job_ready = !busy_r || (out_ready && is_last);
  assign load      = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 4'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= 4'd0;
    end else if (out_fire) begin
      if (is_last) busy_r <= 1'b0;
      else         idx_r  <= idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r  <= job;
      list_r <= job_list;
    end
  end

  assign out_valid       = busy_r;
  assign out_status      = job_r.status;
  assign out_lapic_base  = job_r.lapic_base;
  assign out_usable_cpus = job_r.usable_cpus;
  assign out_cpu_slot    = job_r.has_ids ? idx_r : 4'd0;
  assign out_apic_id     = job_r.has_ids ? list_r[idx_r[IDX_W-1:0]] : NO_ID;
  assign out_last_result = is_last;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= job_r.last_idx))
    else $error("result index past last");

  a_noid_single: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !job_r.has_ids) |-> (job_r.last_idx == 4'd0 && idx_r == 4'd0))
    else $error("idless job with more than one result");

  a_bad_is_bare: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && job_r.status != ST_OK) |->
      (!job_r.has_ids && job_r.lapic_base == 64'd0 && job_r.usable_cpus == 5'd0))
    else $error("failed table carries data");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !is_last) |=> (busy_r && idx_r == $past(idx_r) + 4'd1))
    else $error("result sequence skipped");

endmodule

`default_nettype wire

>>> design/madt_table_stream_parser_top.sv
// ----------------------------------------------------------------------------
// madt_table_stream_parser_top
// MADT byte-stream parser: signature, length, checksum, LAPIC base and ids.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless input stalls; results drain at one per cycle
// while the sink is ready. Final byte: input register, then emitter job register.
// Input stalls only when a table ends while the previous table's results,
// held in the emitter's single job register, are not all taken yet.
// Reset: synchronous, active low; clears handshake state and restarts the table.
`default_nettype none

module madt_table_stream_parser_top
  import madt_pkg::*;
#(
  parameter int unsigned MAX_CPUS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  madt_in_if.sink    in_ch,
  madt_out_if.source out_ch
);

  localparam int unsigned LIST_DEPTH = (MAX_CPUS < MAX_OUT) ? MAX_CPUS : MAX_OUT;

  logic       job_valid;
  logic       job_ready;
  madt_job_t  job;
  logic [7:0] job_list [LIST_DEPTH];

  madt_parse #(.MAX_CPUS(MAX_CPUS)) u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_table_byte (in_ch.table_byte),
    .in_stream_end (in_ch.stream_end),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job           (job),
    .job_list      (job_list)
  );

  madt_emit #(.MAX_CPUS(MAX_CPUS)) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job_ready       (job_ready),
    .job             (job),
    .job_list        (job_list),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_lapic_base  (out_ch.lapic_base),
    .out_usable_cpus (out_ch.usable_cpus),
    .out_cpu_slot    (out_ch.cpu_slot),
    .out_apic_id     (out_ch.apic_id),
    .out_last_result (out_ch.last_result)
  );

endmodule

`default_nettype wire

>>> dv/tb_madt_table_stream_parser_top.sv
// ----------------------------------------------------------------------------
// tb_madt_table_stream_parser_top
// Self-checking bench for the MADT stream parser. A short table of error and
// minimal tables runs first with typed-in results. Random tables follow, most
// of them well formed with random entries, some corrupted, truncated or pure
// noise. Every later result transaction is checked against a behavioural model of
// the parser, under several patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------

module tb_madt_table_stream_parser_top;
  import madt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_CPUS     = 16;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned MIN_BYTES    = 300;
  localparam int unsigned MIN_TABLES   = 4;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] lapic_base;
    logic [4:0]  usable_cpus;
    logic [3:0]  cpu_slot;
    logic [7:0]  apic_id;
    logic        last_result;
  } madt_report_t;

  typedef struct packed {
    logic [7:0] tbyte;
    logic       last;
    logic       has_exp;
    logic [1:0] exp_status;
  } directed_row_t;

  // error tables and one minimal valid table; results read straight off the bytes
  localparam int unsigned N_DIRECTED = 27;
  directed_row_t directed_rows [N_DIRECTED] = '{
    // bad signature, length 0 so the table closes at byte 7
    '{8'h58, 1'b0, 1'b0, ST_OK},  '{8'h50, 1'b0, 1'b0, ST_OK},
    '{8'h49, 1'b0, 1'b0, ST_OK},  '{8'h43, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},  '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},  '{8'h00, 1'b0, 1'b1, ST_BAD_SIG},
    // bad checksum, table end and stream end on the same byte
    '{8'h41, 1'b0, 1'b0, ST_OK},  '{8'h50, 1'b0, 1'b0, ST_OK},
    '{8'h49, 1'b0, 1'b0, ST_OK},  '{8'h43, 1'b0, 1'b0, ST_OK},
    '{8'h08, 1'b0, 1'b0, ST_OK},  '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},  '{8'h00, 1'b1, 1'b1, ST_BAD_SUM},
    // truncated wins over a bad signature
    '{8'hFF, 1'b0, 1'b0, ST_OK},  '{8'h50, 1'b1, 1'b1, ST_TRUNC},
    // nine-byte valid table, no entries, base never reached
    '{8'h41, 1'b0, 1'b0, ST_OK},  '{8'h50, 1'b0, 1'b0, ST_OK},
    '{8'h49, 1'b0, 1'b0, ST_OK},  '{8'h43, 1'b0, 1'b0, ST_OK},
    '{8'h09, 1'b0, 1'b0, ST_OK},  '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK},  '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'hDA, 1'b0, 1'b1, ST_OK}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  madt_in_if  in_ch ();
  madt_out_if out_ch ();

  madt_table_stream_parser_top #(.MAX_CPUS(MAX_CPUS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser model state
  logic [31:0] byte_off;
  logic [31:0] tbl_len;
  logic [7:0]  byte_sum;
  logic        sig_ok;
  logic [7:0]  ent_pos;
  logic [7:0]  ent_type;
  logic [7:0]  ent_len;
  logic        walk_stopped;
  logic [7:0]  pending_id;
  logic [1:0]  pending_flags;
  logic [63:0] ovr_accum;
  logic [63:0] base_addr;
  logic [7:0]  cpu_ids [MAX_CPUS];
  int unsigned id_count;

  madt_report_t step_reports [$];
  madt_report_t madt_reports_due [$];

  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned tables_sent   = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_requests = 0;

  function automatic void clear_parser_state();
    byte_off      = '0;
    tbl_len       = '0;
    byte_sum      = '0;
    sig_ok        = 1'b1;
    ent_pos       = '0;
    ent_type      = '0;
    ent_len       = '0;
    walk_stopped  = 1'b0;
    pending_id    = '0;
    pending_flags = '0;
    ovr_accum     = '0;
    base_addr     = '0;
    id_count      = 0;
    foreach (cpu_ids[i]) cpu_ids[i] = '0;
  endfunction

  function automatic void advance_entry_walk(input logic [7:0] b);
    logic [7:0] pos;
    pos = ent_pos;
    if (pos == 8'd0) begin
      ent_type = b;
    end else if (pos == 8'd1) begin
      ent_len = b;
      // byte_off still points at this byte, so the entry began one earlier
      if (b < ENTRY_MIN_LEN || (64'(byte_off) - 64'd1 + 64'(b)) > 64'(tbl_len)) begin
        walk_stopped = 1'b1;
        return;
      end
    end else if (ent_type == TYPE_LAPIC && ent_len >= LAPIC_MIN_LEN) begin
      if (pos == 8'd3) pending_id = b;
      if (pos == 8'd4) begin
        pending_flags = b[1:0];
        if (pending_flags != 2'b00 && id_count < MAX_CPUS) begin
          cpu_ids[id_count] = pending_id;
          id_count++;
        end
      end
    end else if (ent_type == TYPE_LAPIC_OVR && ent_len >= OVERRIDE_MIN_LEN) begin
      if (pos >= 8'd4 && pos <= 8'd11) begin
        ovr_accum = ovr_accum | (64'(b) << ((int'(pos) - 4) * 8));
        if (pos == 8'd11) base_addr = ovr_accum;
      end
    end

    if (pos >= 8'd1 && (9'(pos) + 9'd1) >= 9'(ent_len)) begin
      ent_pos   = '0;
      ovr_accum = '0;
    end else begin
      ent_pos = pos + 8'd1;
    end
  endfunction

  function automatic void parse_madt_byte(input logic [7:0] b, input logic last);
    logic [31:0]  off;
    logic         done;
    logic [1:0]   st;
    int unsigned  n;
    madt_report_t r;
    off = byte_off;
    step_reports.delete();
    byte_sum = byte_sum + b;
    if (off < 4) begin
      if (b != MADT_SIGNATURE[off * 8 +: 8]) sig_ok = 1'b0;
    end else if (off < 8) begin
      tbl_len = tbl_len | (32'(b) << ((off - 4) * 8));
    end else if (off >= BASE_AT && off < BASE_AT + 4) begin
      base_addr = base_addr | (64'(b) << ((off - BASE_AT) * 8));
    end else if (off >= ENTRIES_AT && !walk_stopped) begin
      advance_entry_walk(b);
    end

    done = (off >= 7) && (64'(off) + 64'd1 >= 64'(tbl_len));
    if (!done && !last) begin
      byte_off = off + 1;
      return;
    end

    if (!done)              st = ST_TRUNC;
    else if (!sig_ok)       st = ST_BAD_SIG;
    else if (byte_sum != 0) st = ST_BAD_SUM;
    else                    st = ST_OK;

    if (st != ST_OK || id_count == 0) begin
      r.status      = st;
      r.lapic_base  = (st == ST_OK) ? base_addr : 64'd0;
      r.usable_cpus = '0;
      r.cpu_slot    = '0;
      r.apic_id     = NO_ID;
      r.last_result = 1'b1;
      step_reports.push_back(r);
    end else begin
      n = (id_count < MAX_OUT) ? id_count : MAX_OUT;
      for (int k = 0; k < n; k++) begin
        r.status      = ST_OK;
        r.lapic_base  = base_addr;
        r.usable_cpus = (id_count < 31) ? 5'(id_count) : 5'd31;
        r.cpu_slot    = 4'(k);
        r.apic_id     = cpu_ids[k];
        r.last_result = (k + 1 == n);
        step_reports.push_back(r);
      end
    end
    clear_parser_state();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input logic keep_prediction);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.table_byte <= b;
    in_ch.stream_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_madt_byte(b, last);
    if (keep_prediction) begin
      foreach (step_reports[i]) madt_reports_due.push_back(step_reports[i]);
    end
    bytes_sent++;
  endtask

  // random bytes, closed by a stream end
  task automatic send_noise_burst(input int unsigned n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), (i == n - 1), 1'b1);
  endtask

  task automatic send_random_table();
    logic [7:0]  frame [$];
    logic [7:0]  etype;
    logic [7:0]  elen;
    logic        crowded;
    logic        short_form;
    logic        truncated;
    logic        end_here;
    int unsigned n_entries;
    int unsigned pick;
    int unsigned start;
    int unsigned k;
    int unsigned table_len;
    int unsigned stop_at;
    int unsigned idx;
    int          sum;

    for (int i = 0; i < ENTRIES_AT; i++) frame.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) frame[i] = MADT_SIGNATURE[i * 8 +: 8];

    short_form = ($urandom_range(99) < 6);
    crowded    = !short_form && ($urandom_range(99) < 12);
    n_entries  = short_form ? 0 : (crowded ? $urandom_range(24, 17) : $urandom_range(6, 0));

    for (int e = 0; e < n_entries; e++) begin
      pick = $urandom_range(99);
      if (crowded && pick < 90) pick = 0;
      start = frame.size();
      if (pick < 45) begin
        etype = TYPE_LAPIC;
        elen  = LAPIC_MIN_LEN;
      end else if (pick < 60) begin
        etype = TYPE_LAPIC_OVR;
        elen  = OVERRIDE_MIN_LEN;
      end else if (pick < 75) begin
        etype = 8'($urandom_range(255, 1));
        elen  = 8'($urandom_range(14, 2));
      end else if (pick < 85) begin
        // too short to be used
        etype = $urandom_range(1) ? TYPE_LAPIC : TYPE_LAPIC_OVR;
        elen  = 8'($urandom_range((etype == TYPE_LAPIC) ? 7 : 11, 2));
      end else begin
        etype = $urandom_range(1) ? TYPE_LAPIC : TYPE_LAPIC_OVR;
        elen  = (etype == TYPE_LAPIC) ? 8'($urandom_range(16, 9)) : 8'($urandom_range(20, 13));
      end
      frame.push_back(etype);
      frame.push_back(elen);
      repeat (int'(elen) - 2) frame.push_back(8'($urandom));
      if (crowded && etype == TYPE_LAPIC && elen >= LAPIC_MIN_LEN)
        frame[start + 4] = frame[start + 4] | 8'h01;
    end

    if (short_form) begin
      table_len = $urandom_range(43, 10);
      while (frame.size() > table_len) void'(frame.pop_back());
    end else begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        // entry length below two stops the walk
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom_range(1)));
        repeat ($urandom_range(6)) frame.push_back(8'($urandom));
      end else if (pick < 14) begin
        // last entry claims more bytes than the table holds
        k = $urandom_range(4);
        frame.push_back($urandom_range(1) ? TYPE_LAPIC : TYPE_LAPIC_OVR);
        frame.push_back(8'($urandom_range(255, 3 + k)));
        repeat (k) frame.push_back(8'($urandom));
      end
      table_len = frame.size();
    end

    for (int i = 0; i < 4; i++) frame[4 + i] = 8'(table_len >> (8 * i));
    frame[9] = '0;
    sum = 0;
    foreach (frame[i]) sum += frame[i];
    frame[9] = 8'(0 - sum);

    truncated = 1'b0;
    pick = $urandom_range(99);
    if (pick < 8) begin
      idx = $urandom_range(3);
      frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(7));
    end else if (pick < 16) begin
      idx = $urandom_range(frame.size() - 1, 8);
      frame[idx] = frame[idx] + 8'($urandom_range(255, 1));
    end else if (pick < 24) begin
      truncated = 1'b1;
    end

    stop_at  = truncated ? $urandom_range(frame.size() - 1, 1) : frame.size();
    end_here = truncated ? 1'b1 : 1'($urandom_range(1));
    for (int i = 0; i < stop_at; i++) send_byte(frame[i], end_here && (i == stop_at - 1), 1'b1);
  endtask

  // sink: random stalls, and a long hold-off on request
  initial begin
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served = 0;
    hold_left   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : report_monitor
    madt_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (madt_reports_due.size() == 0) begin
        $error("result transaction with nothing outstanding: status %0d apic_id %0h",
               out_ch.status, out_ch.apic_id);
        fail_count++;
      end else begin
        want = madt_reports_due.pop_front();
        check_field("status",      64'(want.status),      64'(out_ch.status));
        check_field("lapic_base",  want.lapic_base,       out_ch.lapic_base);
        check_field("usable_cpus", 64'(want.usable_cpus), 64'(out_ch.usable_cpus));
        check_field("cpu_slot",    64'(want.cpu_slot),    64'(out_ch.cpu_slot));
        check_field("apic_id",     64'(want.apic_id),     64'(out_ch.apic_id));
        check_field("last_result", 64'(want.last_result), 64'(out_ch.last_result));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    madt_report_t r;
    int unsigned  phase;
    clear_parser_state();
    in_ch.valid      <= 1'b0;
    in_ch.table_byte <= '0;
    in_ch.stream_end <= 1'b0;
    rst_n            <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].tbyte, directed_rows[i].last, !directed_rows[i].has_exp);
      if (directed_rows[i].has_exp) begin
        r.status      = directed_rows[i].exp_status;
        r.lapic_base  = '0;
        r.usable_cpus = '0;
        r.cpu_slot    = '0;
        r.apic_id     = NO_ID;
        r.last_result = 1'b1;
        madt_reports_due.push_back(r);
      end
    end

    while (bytes_sent < MIN_BYTES || tables_sent < MIN_TABLES) begin
      phase = tables_sent % 4;
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
        1: begin src_idle_pct = 72; sink_stall_pct <= 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct <= 72; end
        default: begin src_idle_pct = 31; sink_stall_pct <= 31; end
      endcase
      if (tables_sent == 2) begin
        // sink holds off while short tables keep arriving, so the input backs up
        src_idle_pct = 0;
        hold_requests <= hold_requests + 1;
        repeat (8) send_noise_burst(1);
      end
      if ($urandom_range(99) < 15) send_noise_burst($urandom_range(12, 1));
      else send_random_table();
      tables_sent++;
    end

    in_ch.valid    <= 1'b0;
    sink_stall_pct <= 0;
    while (madt_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/madt_pkg.sv
design/madt_if.sv
design/madt_parse.sv
design/madt_emit.sv
design/madt_table_stream_parser_top.sv
dv/tb_madt_table_stream_parser_top.sv
